// File: rtl/stc_pkg.sv
// Shared types, codes and constants of the self-organizing map block.
// No dependencies; every other file of the block but stc_ram imports it.
package stc_pkg;

    localparam int MAP_SIZE_DEF   = 16;
    localparam int DIMENSIONS_DEF = 64;

    localparam int VAL_W   = 17;
    localparam int DIST_W  = 39;
    localparam int DIV_W   = 33;
    localparam int STEP_W  = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [VAL_W-1:0]  ONE_Q16  = 17'd65536;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Action codes of an input item; the last code is unused and ignored.
    localparam logic [1:0] ACT_WRITE    = 2'd0;
    localparam logic [1:0] ACT_TRAIN    = 2'd1;
    localparam logic [1:0] ACT_CLASSIFY = 2'd2;
    localparam logic [1:0] ACT_UNUSED   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_TOTAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE  = 1'd1;

    localparam logic [STEP_W-1:0] STEPS_TOTAL_RST = 16'd1000;
    localparam logic [VAL_W-1:0]  LEARN_RATE_RST  = 17'd32768;

    typedef struct packed {
        logic [1:0]       action;
        logic [3:0]       row;
        logic [3:0]       col;
        logic [5:0]       dim;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_item;

    typedef struct packed {
        logic [3:0]        bmu_row;
        logic [3:0]        bmu_col;
        logic [DIST_W-1:0] best_distance;
        logic              updated;
    } t_result;

    // Decoded command passed from the front end to the engine.
    typedef struct packed {
        logic             is_weight;
        logic             store;
        logic             search;
        logic             train;
        logic [3:0]       row;
        logic [3:0]       col;
        logic [5:0]       dim;
        logic [VAL_W-1:0] value;
    } t_cmd;

endpackage

// File: rtl/som_train_and_classify.sv
// Top level of the self-organizing map: front end, command queue and engine.
// Depends on stc_pkg, stc_front, stc_back (with stc_ram and stc_div).
//
// Usage. A request is taken at a clock edge with start high and busy low.
// Weight writes load one weight; training and classify requests stream the
// sample components. The component marked last starts a search over all
// nodes: one weight read per cycle, set by the single read port of the
// weight memory. A training sample then takes two divisions for the learn
// rate and radius, when the step total is non-zero, and a second pass over
// all weights that rewrites them. A two-entry queue lets requests in
// while the engine works; busy is high only while it is full. Each result
// is shown for one cycle with o_done high; the receiver cannot stall it.
// Configuration writes are always ready and are to be made while the block
// is idle; the block itself does not enforce this. Synchronous reset clears
// the step counter and loads the register defaults; weights and sample
// buffer stay undefined until written.
module som_train_and_classify #(
    parameter int MAP_SIZE   = stc_pkg::MAP_SIZE_DEF,
    parameter int DIMENSIONS = stc_pkg::DIMENSIONS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  stc_pkg::t_item                i_item,
    output logic                          o_done,
    output stc_pkg::t_result              o_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [stc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stc_pkg::VAL_W-1:0]     i_cfg_data
);
    import stc_pkg::*;

    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    assign o_cfg_ready = 1'b1;

    // Request decoding and queue.
    stc_front #(.MAP_SIZE(MAP_SIZE), .DIMENSIONS(DIMENSIONS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_item    (i_item),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    // Search and update engine.
    stc_back #(.MAP_SIZE(MAP_SIZE), .DIMENSIONS(DIMENSIONS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_done      (o_done),
        .o_res       (o_res)
    );
endmodule

// File: rtl/stc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module stc_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/stc_front.sv
// Front end: accepts requests, decodes them into commands and queues them.
// Depends on stc_pkg.
module stc_front #(
    parameter int MAP_SIZE   = 16,
    parameter int DIMENSIONS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  stc_pkg::t_item i_item,
    output logic           o_q_valid,
    output stc_pkg::t_cmd  o_q_cmd,
    input  logic           i_q_pop
);
    import stc_pkg::*;

    t_cmd       cmd;
    logic       keep;
    logic       push;
    logic       row_ok, col_ok, dim_ok;
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    // Decode the request and clamp its value to one.
    always_comb begin
        row_ok = 32'(i_item.row) < MAP_SIZE;
        col_ok = 32'(i_item.col) < MAP_SIZE;
        dim_ok = 32'(i_item.dim) < DIMENSIONS;
        cmd.row   = i_item.row;
        cmd.col   = i_item.col;
        cmd.dim   = i_item.dim;
        cmd.value = (i_item.value > ONE_Q16) ? ONE_Q16 : i_item.value;
        cmd.is_weight = 1'b0;
        cmd.store  = 1'b0;
        cmd.search = 1'b0;
        cmd.train  = 1'b0;
        keep = 1'b0;
        unique case (i_item.action)
            ACT_WRITE: begin
                cmd.is_weight = 1'b1;
                keep = row_ok && col_ok && dim_ok;
            end
            ACT_TRAIN, ACT_CLASSIFY: begin
                cmd.store  = dim_ok;
                cmd.search = i_item.last;
                cmd.train  = (i_item.action == ACT_TRAIN);
                keep = dim_ok || i_item.last;
            end
            default: keep = 1'b0;
        endcase
    end

    assign busy = (r_cnt == 2'd2);
    assign push = start && !busy && keep;

    // Two-entry command queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_q_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rp];
endmodule

// File: rtl/stc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on stc_pkg.
module stc_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic [stc_pkg::DIV_W-1:0] i_num,
    input  logic [15:0]               i_den,
    output logic                      o_done,
    output logic [stc_pkg::DIV_W-1:0] o_quot
);
    import stc_pkg::*;

    logic [DIV_W-1:0] r_num;
    logic [15:0]      r_den;
    logic [15:0]      r_rem;
    logic [5:0]       r_cnt;
    logic             r_run;
    logic             r_done;
    logic [16:0]      trial;
    logic             take;

    assign trial = {r_rem, r_num[DIV_W-1]};
    assign take  = trial >= {1'b0, r_den};

    // Shift one numerator bit into the remainder each cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_run <= 1'b1;
                r_cnt <= 6'(DIV_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= 16'd0;
        end else if (r_run) begin
            r_rem <= take ? 16'(trial - {1'b0, r_den}) : trial[15:0];
            r_num <= {r_num[DIV_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
endmodule

// File: rtl/stc_back.sv
// Engine: stores weights and samples, runs the search and update passes.
// Depends on stc_pkg, stc_ram and stc_div.
module stc_back #(
    parameter int MAP_SIZE   = 16,
    parameter int DIMENSIONS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  stc_pkg::t_cmd                 i_q_cmd,
    output logic                          o_q_pop,
    input  logic                          i_cfg_valid,
    input  logic [stc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stc_pkg::VAL_W-1:0]     i_cfg_data,
    output logic                          o_done,
    output stc_pkg::t_result              o_res
);
    import stc_pkg::*;

    localparam int NODES = MAP_SIZE * MAP_SIZE;
    localparam int TOTAL = NODES * DIMENSIONS;
    localparam int WAW   = $clog2(TOTAL);
    localparam int KW    = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
    localparam int RW    = $clog2(MAP_SIZE);
    localparam int RGW   = $clog2(2 * MAP_SIZE + 1);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_SCAN      = 4'd1;
    localparam logic [3:0] ST_DRAIN     = 4'd2;
    localparam logic [3:0] ST_PREP      = 4'd3;
    localparam logic [3:0] ST_MUL       = 4'd4;
    localparam logic [3:0] ST_DIV_RATE  = 4'd5;
    localparam logic [3:0] ST_DIV_RANGE = 4'd6;
    localparam logic [3:0] ST_OUT       = 4'd7;

    logic [3:0]  r_state, n_state;
    logic [STEP_W-1:0] r_total;
    logic [VAL_W-1:0]  r_lr;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] r_left;
    logic [VAL_W-1:0]  r_rate;
    logic [RGW-1:0]    r_range;
    logic              r_train;
    logic              r_upd_mode;

    // Scan counters.
    logic [WAW-1:0] r_addr;
    logic [KW-1:0]  r_k;
    logic [RW-1:0]  r_i, r_j;

    // Pipeline stage registers.
    logic           r_s1_v, r_s1_firstk, r_s1_lastk, r_s1_node0, r_s1_in;
    logic [RW-1:0]  r_s1_row, r_s1_col;
    logic [WAW-1:0] r_s1_addr;
    logic           r_s2_v, r_s2_firstk, r_s2_lastk, r_s2_node0, r_s2_in;
    logic [RW-1:0]  r_s2_row, r_s2_col;
    logic [WAW-1:0] r_s2_addr;
    logic [VAL_W-1:0] r_s2_w;
    logic [33:0]    r_sq;
    logic signed [35:0] r_prod;
    logic           r_s3_v, r_s3_lastk, r_s3_node0;
    logic [RW-1:0]  r_s3_row, r_s3_col;
    logic [DIST_W-1:0] r_acc;

    logic [RW-1:0]     r_best_row, r_best_col;
    logic [DIST_W-1:0] r_best;
    logic              r_done;
    t_result           r_res;

    logic              r_div_go;
    logic [DIV_W-1:0]  r_div_num;
    logic              div_done;
    logic [DIV_W-1:0]  div_quot;

    logic [VAL_W-1:0] w_rd, s_rd;
    logic             w_we, s_we;
    logic [WAW-1:0]   w_waddr;
    logic [VAL_W-1:0] w_wdata;
    logic [RW-1:0]    dr, dc;
    logic             in_range;
    logic [VAL_W-1:0] absd;
    logic signed [17:0] diff;
    logic [39:0]      acc_sum;
    logic [DIST_W-1:0] acc_in;
    logic signed [20:0] delta, nw;
    logic [VAL_W-1:0] nw_c;
    logic [STEP_W-1:0] step_next;
    logic [VAL_W-1:0]  lr_c;
    logic              scan_end;
    logic              pipe_empty;

    // Memories.
    stc_ram #(.WIDTH(VAL_W), .DEPTH(TOTAL)) u_wram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rd)
    );

    stc_ram #(.WIDTH(VAL_W), .DEPTH(DIMENSIONS)) u_sram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (KW'(i_q_cmd.dim)),
        .i_wdata (i_q_cmd.value),
        .i_raddr (r_k),
        .o_rdata (s_rd)
    );

    stc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_div_go),
        .i_num   (r_div_num),
        .i_den   (r_total),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_q_pop = (r_state == ST_IDLE) && i_q_valid;
    assign s_we    = o_q_pop && i_q_cmd.store;

    // Weight writes come from requests when idle and from the update pass.
    always_comb begin
        if (r_state == ST_IDLE) begin
            w_we    = o_q_pop && i_q_cmd.is_weight;
            w_waddr = WAW'((32'(i_q_cmd.row) * MAP_SIZE + 32'(i_q_cmd.col)) * DIMENSIONS
                           + 32'(i_q_cmd.dim));
            w_wdata = i_q_cmd.value;
        end else begin
            w_we    = r_s2_v && r_upd_mode && r_s2_in;
            w_waddr = r_s2_addr;
            w_wdata = nw_c;
        end
    end

    // Manhattan distance of the scanned node from the winner.
    always_comb begin
        dr = (r_i > r_best_row) ? r_i - r_best_row : r_best_row - r_i;
        dc = (r_j > r_best_col) ? r_j - r_best_col : r_best_col - r_j;
        in_range = (32'(dr) + 32'(dc)) <= 32'(r_range);
    end

    // Datapath arithmetic for the stages.
    always_comb begin
        absd = (w_rd > s_rd) ? w_rd - s_rd : s_rd - w_rd;
        diff = $signed({1'b0, s_rd}) - $signed({1'b0, w_rd});
        acc_in  = r_s2_firstk ? '0 : r_acc;
        acc_sum = {1'b0, acc_in} + {6'd0, r_sq};
        delta = 21'(r_prod >>> 16);
        nw    = $signed({4'd0, r_s2_w}) + delta;
        if (nw < 0) begin
            nw_c = '0;
        end else if (nw > $signed({4'd0, ONE_Q16})) begin
            nw_c = ONE_Q16;
        end else begin
            nw_c = nw[VAL_W-1:0];
        end
        step_next  = (r_step < r_total) ? r_step + 16'd1 : r_step;
        lr_c       = (r_lr > ONE_Q16) ? ONE_Q16 : r_lr;
        scan_end   = (r_addr == WAW'(TOTAL - 1));
        pipe_empty = !r_s1_v && !r_s2_v && !r_s3_v;
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (o_q_pop && i_q_cmd.search) n_state = ST_SCAN;
            ST_SCAN:      if (scan_end) n_state = ST_DRAIN;
            ST_DRAIN: begin
                if (pipe_empty) begin
                    n_state = (!r_upd_mode && r_train) ? ST_PREP : ST_OUT;
                end
            end
            ST_PREP:      n_state = ST_MUL;
            ST_MUL:       n_state = (r_total == '0) ? ST_SCAN : ST_DIV_RATE;
            ST_DIV_RATE:  if (div_done) n_state = ST_DIV_RANGE;
            ST_DIV_RANGE: if (div_done) n_state = ST_SCAN;
            ST_OUT:       n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_total  <= STEPS_TOTAL_RST;
            r_lr     <= LEARN_RATE_RST;
            r_step   <= '0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s3_v   <= 1'b0;
            r_done   <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_v   <= (r_state == ST_SCAN);
            r_s2_v   <= r_s1_v;
            r_s3_v   <= r_s2_v && !r_upd_mode;
            r_done   <= (r_state == ST_OUT);
            r_div_go <= (r_state == ST_MUL && r_total != '0)
                     || (r_state == ST_DIV_RATE && div_done);
            if (r_state == ST_PREP) begin
                r_step <= step_next;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_STEPS_TOTAL: r_total <= i_cfg_data[STEP_W-1:0];
                    REG_LEARN_RATE:  r_lr    <= i_cfg_data;
                    default:         r_lr    <= r_lr;
                endcase
            end
        end
    end

    // Scan counters, training parameters and pipeline payload.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && o_q_pop && i_q_cmd.search) begin
            r_train    <= i_q_cmd.train;
            r_upd_mode <= 1'b0;
        end
        if ((r_state == ST_IDLE && o_q_pop) || n_state == ST_SCAN && r_state != ST_SCAN) begin
            r_addr <= '0;
            r_k    <= '0;
            r_i    <= '0;
            r_j    <= '0;
        end else if (r_state == ST_SCAN) begin
            r_addr <= r_addr + WAW'(1);
            if (r_k == KW'(DIMENSIONS - 1)) begin
                r_k <= '0;
                if (r_j == RW'(MAP_SIZE - 1)) begin
                    r_j <= '0;
                    r_i <= r_i + RW'(1);
                end else begin
                    r_j <= r_j + RW'(1);
                end
            end else begin
                r_k <= r_k + KW'(1);
            end
        end
        if (r_state == ST_PREP) begin
            r_left <= (r_total > step_next) ? r_total - step_next : '0;
        end
        if (r_state == ST_MUL) begin
            r_upd_mode <= 1'b1;
            r_div_num  <= DIV_W'(r_left) * DIV_W'(lr_c);
            if (r_total == '0) begin
                r_rate  <= '0;
                r_range <= '0;
            end
        end
        if (r_state == ST_DIV_RATE && div_done) begin
            r_rate    <= div_quot[VAL_W-1:0];
            r_div_num <= DIV_W'(32'(r_left) * 2 * MAP_SIZE);
        end
        if (r_state == ST_DIV_RANGE && div_done) begin
            r_range <= RGW'(div_quot);
        end

        // Stage one: address issued, read data arrives next cycle.
        r_s1_firstk <= (r_k == '0);
        r_s1_lastk  <= (r_k == KW'(DIMENSIONS - 1));
        r_s1_node0  <= (r_i == '0) && (r_j == '0);
        r_s1_row    <= r_i;
        r_s1_col    <= r_j;
        r_s1_addr   <= r_addr;
        r_s1_in     <= in_range;

        // Stage two: square of the difference, or rate times difference.
        r_s2_firstk <= r_s1_firstk;
        r_s2_lastk  <= r_s1_lastk;
        r_s2_node0  <= r_s1_node0;
        r_s2_row    <= r_s1_row;
        r_s2_col    <= r_s1_col;
        r_s2_addr   <= r_s1_addr;
        r_s2_in     <= r_s1_in;
        r_s2_w      <= w_rd;
        r_sq        <= absd * absd;
        r_prod      <= $signed({1'b0, r_rate}) * diff;

        // Stage three: saturating accumulation of the node distance.
        if (r_s2_v && !r_upd_mode) begin
            r_acc <= (acc_sum > {1'b0, DIST_MAX}) ? DIST_MAX : acc_sum[DIST_W-1:0];
        end
        r_s3_lastk <= r_s2_lastk;
        r_s3_node0 <= r_s2_node0;
        r_s3_row   <= r_s2_row;
        r_s3_col   <= r_s2_col;

        // Keep the first node with the least distance.
        if (r_s3_v && r_s3_lastk && (r_s3_node0 || r_acc < r_best)) begin
            r_best     <= r_acc;
            r_best_row <= r_s3_row;
            r_best_col <= r_s3_col;
        end

        if (r_state == ST_OUT) begin
            r_res.bmu_row       <= 4'(r_best_row);
            r_res.bmu_col       <= 4'(r_best_col);
            r_res.best_distance <= r_best;
            r_res.updated       <= r_train;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule
